>>> rtl/core/gbn_pkg.sv
// Go-Back-N sender package: event, phase and sequencer state types, the
// controller/datapath command and status structs, register indexes and widths.
// No dependencies.
`timescale 1ns / 1ps

package gbn_pkg;

    localparam int FRAME_BITS  = 16;
    localparam int COUNT_BITS  = 32;
    localparam int BASE_BITS   = FRAME_BITS + 1;
    localparam int WBITS_W     = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BITS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT = 1'd1;

    localparam logic [WBITS_W-1:0]    WBITS_RESET       = 3'd3;
    localparam logic [FRAME_BITS-1:0] FRAME_COUNT_RESET = 16'd16;

    typedef enum logic [2:0] {
        EV_SENT  = 3'd0,
        EV_ACK   = 3'd1,
        EV_FAIL  = 3'd2,
        EV_SLIDE = 3'd3,
        EV_DONE  = 3'd4
    } event_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_AWAIT,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_SLIDE,
        ST_SEND,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        FSEL_ZERO,
        FSEL_ACK,
        FSEL_SENT
    } frame_sel_t;

    typedef struct packed {
        logic        accept;
        logic        start;
        logic        emit;
        event_kind_t kind;
        frame_sel_t  frame_sel;
        logic        bump;
        logic        ack_inc;
        logic        slide;
        logic        send_step;
        logic        set_await;
        logic        set_done;
        logic        last;
    } gbn_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   lost;
        logic   empty;
        logic   ack_is_last;
        logic   slide_done;
        logic   burst_last;
        logic   emit_ok;
    } gbn_stat_t;

endpackage

>>> rtl/core/gbn_ctrl.sv
// Go-Back-N sender sequencer: walks one input word through its ack, slide,
// burst and done events. Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  gbn_pkg::gbn_stat_t stat,
    output gbn_pkg::gbn_cmd_t  cmd
);
    import gbn_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Hold the sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!mode)
                    begin
                        state_next = stat.empty ? ST_DONE : ST_SEND;
                    end
                    else if (stat.phase == PH_AWAIT)
                    begin
                        state_next = ST_ACK;
                    end
                end
            end
            ST_ACK:
            begin
                if (stat.emit_ok)
                begin
                    state_next = (stat.lost || stat.ack_is_last) ? ST_SLIDE : ST_IDLE;
                end
            end
            ST_SLIDE:
            begin
                if (stat.emit_ok)
                begin
                    state_next = stat.slide_done ? ST_DONE : ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (stat.emit_ok && stat.burst_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (stat.emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                cmd.start  = in_valid && !mode;
            end
            ST_ACK:
            begin
                cmd.emit      = stat.emit_ok;
                cmd.frame_sel = FSEL_ACK;
                if (!stat.lost)
                begin
                    cmd.kind    = EV_ACK;
                    cmd.bump    = stat.emit_ok;
                    cmd.ack_inc = stat.emit_ok;
                    cmd.last    = !stat.ack_is_last;
                end
                else
                begin
                    cmd.kind = EV_FAIL;
                end
            end
            ST_SLIDE:
            begin
                cmd.emit  = stat.emit_ok;
                cmd.kind  = EV_SLIDE;
                cmd.slide = stat.emit_ok;
            end
            ST_SEND:
            begin
                cmd.emit      = stat.emit_ok;
                cmd.kind      = EV_SENT;
                cmd.frame_sel = FSEL_SENT;
                cmd.bump      = stat.emit_ok;
                cmd.send_step = stat.emit_ok;
                cmd.set_await = stat.emit_ok && stat.burst_last;
                cmd.last      = stat.burst_last;
            end
            ST_DONE:
            begin
                cmd.emit     = stat.emit_ok;
                cmd.kind     = EV_DONE;
                cmd.set_done = stat.emit_ok;
                cmd.last     = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/gbn_dp.sv
// Go-Back-N sender datapath: configuration registers, window base, ack and
// burst counters, saturating transmission count and the output word register.
// Depends on gbn_pkg.
`timescale 1ns / 1ps

module gbn_dp
#(
    parameter int MAX_WINDOW_BITS = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gbn_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                ack_lost,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [2:0]                          event_kind,
    output logic [gbn_pkg::FRAME_BITS-1:0]      frame_number,
    output logic [gbn_pkg::COUNT_BITS-1:0]      transmissions,
    output logic                                last_of_run,
    input  gbn_pkg::gbn_cmd_t                   cmd,
    output gbn_pkg::gbn_stat_t                  stat
);
    import gbn_pkg::*;

    localparam int MW = MAX_WINDOW_BITS;

    logic [WBITS_W-1:0]    wbits_reg;
    logic [FRAME_BITS-1:0] fcount_reg;
    logic [BASE_BITS-1:0]  base_reg;
    logic [MW-1:0]         acked_reg;
    logic [MW-1:0]         k_reg;
    phase_t                phase_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  lost_reg;
    logic                  out_valid_reg;
    logic [2:0]            out_kind_reg;
    logic [FRAME_BITS-1:0] out_frame_reg;
    logic [COUNT_BITS-1:0] out_trans_reg;
    logic                  out_last_reg;

    logic [WBITS_W-1:0]    wbits_eff;
    logic [MW:0]           win_pow;
    logic [MW-1:0]         win_size;
    logic [BASE_BITS-1:0]  left;
    logic [MW-1:0]         burst_len;
    logic [BASE_BITS:0]    slid_base;
    logic [COUNT_BITS-1:0] count_bumped;
    logic [BASE_BITS-1:0]  frame_full;
    logic                  emit_ok;

    // Clamp window bits into 1..MAX_WINDOW_BITS and form 2^b - 1
    always_comb
    begin
        if (wbits_reg == '0)
        begin
            wbits_eff = WBITS_W'(1);
        end
        else if (32'(wbits_reg) > MW)
        begin
            wbits_eff = WBITS_W'(MW);
        end
        else
        begin
            wbits_eff = wbits_reg;
        end
        win_pow  = (MW+1)'(1) << wbits_eff;
        win_size = MW'(win_pow - (MW+1)'(1));
    end

    // Burst length: frames left from the base, capped by the window
    always_comb
    begin
        left = BASE_BITS'(fcount_reg) - base_reg + BASE_BITS'(1);
        if (base_reg > BASE_BITS'(fcount_reg))
        begin
            burst_len = '0;
        end
        else if (left < BASE_BITS'(win_size))
        begin
            burst_len = left[MW-1:0];
        end
        else
        begin
            burst_len = win_size;
        end
    end

    assign slid_base    = (BASE_BITS+1)'(base_reg) + (BASE_BITS+1)'(acked_reg);
    assign count_bumped = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
    assign emit_ok      = !out_valid_reg || out_ready;

    // Select the frame the event refers to
    always_comb
    begin
        case (cmd.frame_sel)
            FSEL_ACK:  frame_full = base_reg + BASE_BITS'(acked_reg);
            FSEL_SENT: frame_full = base_reg + BASE_BITS'(k_reg);
            default:   frame_full = '0;
        endcase
    end

    // Report status to the sequencer
    always_comb
    begin
        stat.phase       = phase_reg;
        stat.lost        = lost_reg;
        stat.empty       = (fcount_reg == '0);
        stat.ack_is_last = ((MW+1)'(acked_reg) + (MW+1)'(1)) >= (MW+1)'(burst_len);
        stat.slide_done  = slid_base > (BASE_BITS+1)'(fcount_reg);
        stat.burst_last  = ((MW+1)'(k_reg) + (MW+1)'(1)) == (MW+1)'(burst_len);
        stat.emit_ok     = emit_ok;
    end

    // Update configuration and transfer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wbits_reg     <= WBITS_RESET;
            fcount_reg    <= FRAME_COUNT_RESET;
            base_reg      <= BASE_BITS'(1);
            acked_reg     <= '0;
            k_reg         <= '0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WINDOW_BITS)
                begin
                    wbits_reg <= cfg_data[WBITS_W-1:0];
                end
                else if (cfg_index == REG_FRAME_COUNT)
                begin
                    fcount_reg <= cfg_data[FRAME_BITS-1:0];
                end
            end

            if (cmd.start)
            begin
                base_reg  <= BASE_BITS'(1);
                acked_reg <= '0;
                k_reg     <= '0;
                count_reg <= '0;
            end
            else
            begin
                if (cmd.bump)
                begin
                    count_reg <= count_bumped;
                end
                if (cmd.ack_inc)
                begin
                    acked_reg <= acked_reg + MW'(1);
                end
                if (cmd.slide)
                begin
                    base_reg  <= slid_base[BASE_BITS-1:0];
                    acked_reg <= '0;
                    k_reg     <= '0;
                end
                if (cmd.send_step)
                begin
                    k_reg <= k_reg + MW'(1);
                end
            end

            if (cmd.set_await)
            begin
                phase_reg <= PH_AWAIT;
                acked_reg <= '0;
            end
            else if (cmd.set_done)
            begin
                phase_reg <= PH_DONE;
            end

            // Fill on emit, drain when taken
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the ack outcome and the output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            lost_reg <= ack_lost;
        end
        if (cmd.emit)
        begin
            out_kind_reg  <= cmd.kind;
            out_frame_reg <= frame_full[FRAME_BITS-1:0];
            out_trans_reg <= cmd.bump ? count_bumped : count_reg;
            out_last_reg  <= cmd.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_kind_reg;
    assign frame_number  = out_frame_reg;
    assign transmissions = out_trans_reg;
    assign last_of_run   = out_last_reg;

endmodule

>>> rtl/core/go_back_n_sender.sv
// Go-Back-N ARQ sender top level: joins the sequencer and the datapath.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: mode 0 starts a
//   transfer from frame one, mode 1 gives the outcome (ack_lost) of the
//   next awaited frame. Output channel (out_valid/out_ready) carries one
//   event word per cycle while out_ready is high: event_kind, frame_number,
//   transmissions and last_of_run, which marks the final event of each
//   input word. Configuration is written through cfg_we/cfg_index/cfg_data
//   while idle (a rule for the user; the block does not enforce it):
//   index 0 is window_bits, index 1 is frame_count. An input word is taken
//   in the idle state and then causes its events in order, at most an ack,
//   a slide and a full burst; the sequencer emits one event per cycle
//   through a single output register, but a stalled receiver freezes it
//   outside idle until the event is taken. An ack while no transfer awaits
//   one causes no event and in_ready stays high. The last event may sit in
//   the output register while the next word is accepted. Reset: window_bits
//   3, frame_count 16, transfer idle, count zero.
`timescale 1ns / 1ps

module go_back_n_sender
#(
    parameter int MAX_WINDOW_BITS = 5
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbn_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic                            ack_lost,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [2:0]                      event_kind,
    output logic [gbn_pkg::FRAME_BITS-1:0]  frame_number,
    output logic [gbn_pkg::COUNT_BITS-1:0]  transmissions,
    output logic                            last_of_run
);
    import gbn_pkg::*;

    gbn_cmd_t  cmd;
    gbn_stat_t stat;

    // Sequence events
    gbn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold transfer state and the output word
    gbn_dp
    #(
        .MAX_WINDOW_BITS (MAX_WINDOW_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ack_lost      (ack_lost),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .event_kind    (event_kind),
        .frame_number  (frame_number),
        .transmissions (transmissions),
        .last_of_run   (last_of_run),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

>>> rtl/core/gbn_chk.sv
// Go-Back-N sender port checker and its bind to the top level.
// Depends on gbn_pkg and go_back_n_sender.
`timescale 1ns / 1ps

module gbn_chk
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            mode,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [2:0]                      event_kind,
    input logic [gbn_pkg::FRAME_BITS-1:0]  frame_number,
    input logic [gbn_pkg::COUNT_BITS-1:0]  transmissions,
    input logic                            last_of_run
);
    import gbn_pkg::*;

    // A start word always produces events, so the input side must close
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !mode |=> !in_ready)
        else $error("input accepted right after a start word");

    // Stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind)
            && $stable(frame_number) && $stable(transmissions)
            && $stable(last_of_run))
        else $error("stalled output word changed");

    // Done ends the run
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_DONE |-> last_of_run)
        else $error("done event not marked last");

    // Slide and done carry no frame
    a_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == EV_SLIDE || event_kind == EV_DONE)
            |-> frame_number == '0)
        else $error("slide or done event carries a frame number");

endmodule

bind go_back_n_sender gbn_chk u_gbn_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .frame_number  (frame_number),
    .transmissions (transmissions),
    .last_of_run   (last_of_run)
);

>>> bench/go_back_n_sender_tb.sv
// Self-checking bench for the Go-Back-N sender: a directed script, then random transfers
// checked against an in-bench prediction of the event stream.
// Depends on gbn_pkg and go_back_n_sender.
`timescale 1ns / 1ps

module go_back_n_sender_tb;

    import gbn_pkg::*;

    localparam int RANDOM_WORDS  = 96;
    localparam int SETTLE_CYCLES = 40;
    localparam int WBITS_CEILING = 5;

    typedef struct {
        event_kind_t           kind;
        logic [FRAME_BITS-1:0] frame;
        logic [COUNT_BITS-1:0] trans;
        logic                  last;
    } sender_event_t;

    typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

    // pin_count < 0 leaves the row to the prediction alone
    typedef struct {
        row_kind_t              what;
        logic                   mode;
        logic                   lost;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  value;
        int                     pin_count;
        event_kind_t            pin_kind;
        int                     pin_frame;
        int                     pin_trans;
    } script_row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_WINDOW_BITS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic                   mode = 1'b0;
    logic                   ack_lost = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [2:0]             event_kind;
    logic [FRAME_BITS-1:0]  frame_number;
    logic [COUNT_BITS-1:0]  transmissions;
    logic                   last_of_run;

    // predicted sender state and registers
    logic [WBITS_W-1:0]     window_bits_reg;
    logic [FRAME_BITS-1:0]  frame_total;
    int unsigned            win_base;
    int unsigned            win_acked;
    phase_t                 xfer_phase;
    logic [COUNT_BITS-1:0]  send_total;

    sender_event_t          events_due[$];
    script_row_t            script[$];
    int                     err_count = 0;
    bit                     sender_calm = 1'b0;
    bit                     soak_started = 1'b0;

    go_back_n_sender DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .ack_lost      (ack_lost),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .frame_number  (frame_number),
        .transmissions (transmissions),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Window span after clamping the sequence bits into 1..5
    function automatic int unsigned window_size();
        int unsigned b;
        b = window_bits_reg;
        if (b < 1) b = 1;
        if (b > WBITS_CEILING) b = WBITS_CEILING;
        return (1 << b) - 1;
    endfunction

    // Frames still to send from the base, capped by the window
    function automatic int unsigned burst_size();
        int unsigned left;
        if (win_base > frame_total) return 0;
        left = frame_total - win_base + 1;
        return (left < window_size()) ? left : window_size();
    endfunction

    function automatic void count_send();
        if (send_total != '1) send_total = send_total + 1'b1;
    endfunction

    function automatic void note_event(event_kind_t kind, int unsigned frame);
        sender_event_t ev;
        ev.kind  = kind;
        ev.frame = FRAME_BITS'(frame);
        ev.trans = send_total;
        ev.last  = 1'b0;
        events_due.push_back(ev);
    endfunction

    function automatic int send_burst();
        int unsigned len;
        int unsigned k;
        len = burst_size();
        for (k = 0; k < len; k++)
        begin
            count_send();
            note_event(EV_SENT, win_base + k);
        end
        win_acked  = 0;
        xfer_phase = PH_AWAIT;
        return len;
    endfunction

    function automatic int slide_window();
        win_base  = win_base + win_acked;
        win_acked = 0;
        note_event(EV_SLIDE, 0);
        if (win_base > frame_total)
        begin
            xfer_phase = PH_DONE;
            note_event(EV_DONE, 0);
            return 2;
        end
        return 1 + send_burst();
    endfunction

    // Advance the predicted sender by one word; queue the events it causes
    function automatic int events_for_word(logic m, logic l);
        int            n;
        int unsigned   frame;
        sender_event_t tail;
        n = 0;
        if (m == 1'b0)
        begin
            win_base   = 1;
            win_acked  = 0;
            send_total = '0;
            if (frame_total == 0)
            begin
                xfer_phase = PH_DONE;
                note_event(EV_DONE, 0);
                n = 1;
            end
            else
                n = send_burst();
        end
        else if (xfer_phase == PH_AWAIT)
        begin
            frame = win_base + win_acked;
            if (l == 1'b0)
            begin
                count_send();
                note_event(EV_ACK, frame);
                n = 1;
                win_acked++;
                if (win_acked >= burst_size()) n += slide_window();
            end
            else
            begin
                note_event(EV_FAIL, frame);
                n = 1 + slide_window();
            end
        end
        // mark the final event of this word
        if (n > 0)
        begin
            tail = events_due.pop_back();
            tail.last = 1'b1;
            events_due.push_back(tail);
        end
        return n;
    endfunction

    function automatic void add_pinned(logic m, logic l, int count, event_kind_t kind,
                                       int frame, int trans);
        script_row_t row;
        row.what      = ROW_WORD;
        row.mode      = m;
        row.lost      = l;
        row.reg_index = REG_WINDOW_BITS;
        row.value     = '0;
        row.pin_count = count;
        row.pin_kind  = kind;
        row.pin_frame = frame;
        row.pin_trans = trans;
        script.push_back(row);
    endfunction

    function automatic void add_word(logic m, logic l);
        add_pinned(m, l, -1, EV_SENT, 0, 0);
    endfunction

    function automatic void add_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        script_row_t row;
        row.what      = ROW_REG;
        row.mode      = 1'b0;
        row.lost      = 1'b0;
        row.reg_index = idx;
        row.value     = value;
        row.pin_count = -1;
        row.pin_kind  = EV_SENT;
        row.pin_frame = 0;
        row.pin_trans = 0;
        script.push_back(row);
    endfunction

    // Mostly short transfers, now and then empty or very long
    function automatic logic [CFG_DATA_W-1:0] pick_frames();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(41, 65535));
            default: return CFG_DATA_W'($urandom_range(1, 40));
        endcase
    endfunction

    // Sequence bits 0..7, sometimes with junk above the field
    function automatic logic [CFG_DATA_W-1:0] pick_window();
        if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(0, 7));
    endfunction

    // Offer one word, holding it until taken, then predict its events
    task automatic offer_word(logic m, logic l, output int n);
        if (!sender_calm && $urandom_range(0, 99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        ack_lost <= l;
        do @(posedge clk); while (!in_ready);
        n = events_for_word(m, l);
    endtask

    // Drain all due events, then let a word that causes none finish
    task automatic settle();
        in_valid <= 1'b0;
        while (events_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WINDOW_BITS)
            window_bits_reg = value[WBITS_W-1:0];
        else
            frame_total = value;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int            n;
        int            result_words;
        int            acks;
        int            a;
        int            roll;
        bit            pin_bad;
        sender_event_t head;

        window_bits_reg = WBITS_RESET;
        frame_total     = FRAME_COUNT_RESET;
        win_base        = 1;
        win_acked       = 0;
        xfer_phase      = PH_IDLE;
        send_total      = '0;

        // reset settings: window of 7 over 16 frames
        add_pinned(1'b1, 1'b0, 0, EV_SENT, 0, 0);
        add_pinned(1'b1, 1'b1, 0, EV_SENT, 0, 0);
        add_pinned(1'b0, 1'b1, 7, EV_SENT, 1, 1);
        add_pinned(1'b1, 1'b0, 1, EV_ACK, 1, 8);
        add_pinned(1'b1, 1'b1, 9, EV_FAIL, 2, 8);
        add_pinned(1'b0, 1'b0, 7, EV_SENT, 1, 1);
        // shrink to a one-frame window over three frames mid-transfer, run to done
        add_reg(REG_WINDOW_BITS, 16'd0);
        add_reg(REG_FRAME_COUNT, 16'd3);
        add_word(1'b1, 1'b0);
        add_word(1'b1, 1'b1);
        add_word(1'b1, 1'b0);
        add_word(1'b1, 1'b0);
        add_pinned(1'b1, 1'b0, 0, EV_SENT, 0, 0);
        // empty transfer
        add_reg(REG_FRAME_COUNT, 16'd0);
        add_pinned(1'b0, 1'b0, 1, EV_DONE, 0, 0);
        // over-range window bits and the largest frame count
        add_reg(REG_WINDOW_BITS, 16'd7);
        add_reg(REG_FRAME_COUNT, 16'hFFFF);
        add_pinned(1'b0, 1'b0, 31, EV_SENT, 1, 1);
        add_word(1'b1, 1'b0);
        add_word(1'b1, 1'b0);
        add_word(1'b1, 1'b0);
        // window shrinks under acks already taken, then count drops below the base
        add_reg(REG_WINDOW_BITS, 16'd2);
        add_word(1'b1, 1'b0);
        add_reg(REG_FRAME_COUNT, 16'd2);
        add_word(1'b1, 1'b0);
        // full window resent after the first frame fails
        add_reg(REG_WINDOW_BITS, 16'd5);
        add_reg(REG_FRAME_COUNT, 16'd40);
        add_pinned(1'b0, 1'b1, 31, EV_SENT, 1, 1);
        add_pinned(1'b1, 1'b1, 33, EV_FAIL, 1, 31);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed script
        foreach (script[i])
        begin
            if (script[i].what == ROW_REG)
            begin
                settle();
                write_reg(script[i].reg_index, script[i].value);
            end
            else
            begin
                offer_word(script[i].mode, script[i].lost, n);
                if (script[i].pin_count >= 0)
                begin
                    pin_bad = (n != script[i].pin_count);
                    if (!pin_bad && n > 0)
                    begin
                        head    = events_due[events_due.size() - n];
                        pin_bad = head.kind != script[i].pin_kind
                               || head.frame != script[i].pin_frame
                               || head.trans != script[i].pin_trans;
                    end
                    if (pin_bad)
                    begin
                        err_count++;
                        $display("%0t: row %0d expected %0d events from kind %0d",
                                 $time, i, script[i].pin_count, script[i].pin_kind,
                                 " frame %0d count %0d, predicted %0d",
                                 script[i].pin_frame, script[i].pin_trans, n);
                    end
                end
            end
        end

        // random transfers: mostly clean runs of acks, some restarts and reshapes
        soak_started = 1'b1;
        result_words = 0;
        while (result_words < RANDOM_WORDS)
        begin
            sender_calm = (result_words >= 30 && result_words < 60);
            if (result_words == 0 || $urandom_range(0, 2) == 0)
            begin
                settle();
                write_reg(REG_WINDOW_BITS, pick_window());
                write_reg(REG_FRAME_COUNT, pick_frames());
            end
            offer_word(1'b0, 1'($urandom), n);
            if (n > 0) result_words++;
            acks = $urandom_range(4, 60);
            for (a = 0; a < acks && xfer_phase == PH_AWAIT; a++)
            begin
                roll = $urandom_range(0, 99);
                n = 0;
                if (roll < 3)
                    offer_word(1'b0, 1'($urandom), n);
                else if (roll < 6)
                begin
                    settle();
                    if ($urandom_range(0, 1) == 0)
                        write_reg(REG_WINDOW_BITS, pick_window());
                    else
                        write_reg(REG_FRAME_COUNT, pick_frames());
                end
                else
                    offer_word(1'b1, ($urandom_range(0, 99) < 20), n);
                if (n > 0) result_words++;
            end
            // poke a finished transfer now and then
            if ($urandom_range(0, 3) == 0)
            begin
                offer_word(1'b1, 1'($urandom), n);
                if (n > 0) result_words++;
            end
        end

        settle();
        if (err_count == 0)
            $display("PASS go_back_n_sender");
        else
            $display("FAIL go_back_n_sender");
        $finish;
    end

    // Receiver: random stalls, one calm stretch and one long hold-off
    initial
    begin : receiver
        int unsigned cyc;
        int unsigned hold_at;
        cyc     = 0;
        hold_at = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (soak_started && hold_at == 0) hold_at = cyc + 150;
            if (hold_at != 0 && cyc >= hold_at && cyc < hold_at + 300)
                out_ready <= 1'b0;
            else if (cyc > 2000 && cyc < 3500)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 17);
        end
    end

    // Compare each taken event with the oldest one due
    always @(posedge clk)
    begin : event_check
        sender_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (events_due.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected event: expected none,", $time,
                         " got kind %0d frame %0d count %0d last %0d",
                         event_kind, frame_number, transmissions, last_of_run);
            end
            else
            begin
                want = events_due.pop_front();
                if (event_kind !== want.kind || frame_number !== want.frame
                    || transmissions !== want.trans || last_of_run !== want.last)
                begin
                    err_count++;
                    $display("%0t: mismatch: expected kind %0d frame %0d count %0d last %0d",
                             $time, want.kind, want.frame, want.trans, want.last,
                             ", got kind %0d frame %0d count %0d last %0d",
                             event_kind, frame_number, transmissions, last_of_run);
                end
            end
        end
    end

    // Hard stop well past the slowest legal run
    initial
    begin : watchdog
        #(6_000_000);
        $display("FAIL go_back_n_sender");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gbn_pkg.sv
rtl/core/gbn_ctrl.sv
rtl/core/gbn_dp.sv
rtl/core/go_back_n_sender.sv
rtl/core/gbn_chk.sv
bench/go_back_n_sender_tb.sv
